// ----- hw/rtl/lp_pkg.sv -----
// Lomuto partition package: field widths, default capacity and the sequencer states.
// Used by lp_store and lomuto_partition. No dependencies.
`default_nettype none

package lp_pkg;

  localparam int unsigned DATA_W           = 32;
  localparam int unsigned START_W          = 16;
  localparam int unsigned POS_W            = 6;
  localparam int unsigned SPLIT_W          = 17;
  localparam int unsigned DEF_MAX_ELEMENTS = 64;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SCAN_SWAP,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } lp_state_e;

endpackage

`default_nettype wire

// ----- hw/rtl/lp_store.sv -----
// Element store for the Lomuto partition block: one write port, two registered read ports.
// Depends on lp_pkg for the data width.
`default_nettype none

module lp_store #(
  parameter int unsigned DEPTH = lp_pkg::DEF_MAX_ELEMENTS,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic                      clk_i,
  input  wire logic                      we_i,
  input  wire logic [AW-1:0]             waddr_i,
  input  wire logic [lp_pkg::DATA_W-1:0] wdata_i,
  input  wire logic                      re_i,
  input  wire logic [AW-1:0]             raddr_a_i,
  input  wire logic [AW-1:0]             raddr_b_i,
  output logic      [lp_pkg::DATA_W-1:0] rdata_a_o,
  output logic      [lp_pkg::DATA_W-1:0] rdata_b_o
);

  logic [lp_pkg::DATA_W-1:0] mem [DEPTH];
  logic [lp_pkg::DATA_W-1:0] rdata_a_q;
  logic [lp_pkg::DATA_W-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // hold read data unless a read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

// ----- hw/rtl/lomuto_partition.sv -----
// Lomuto partition block: loads a set of signed elements, partitions it around its last
// element and streams the rearranged set out. Depends on lp_pkg and lp_store.
//
// Input channel (in_valid_i/in_ready_o): one element per item, is_last_i closes the set
// and the last kept element is the pivot. start_index_i is sampled on a set's first item.
// Up to MAX_ELEMENTS elements are kept; further items are dropped and flagged by
// overflow_o on every result of the set.
// Output channel (out_valid_o/out_ready_i): one result per stored element, in position
// order, with split_index_o = start index + final pivot offset and last_out_o on the
// final result.
// Sequence: loading writes each kept item to the store. After the closing item, the scan
// reads the element pair (scan position, low boundary) from the two-port store, compares
// against the pivot in the single signed comparator, and swaps through the one write port:
// an element above the pivot takes a read and a compare, one that moves also a swap, and a
// final read ends the scan. Each result takes a store read, an output load and a handshake
// that waits out receiver stalls; the output register holds the result until taken.
// The input is not ready from the closing item until the final result is taken.
// Reset clears the set count, overflow flag, start index and output valid; the store
// itself needs no clearing since only entries of the current set are read.
`default_nettype none

module lomuto_partition #(
  parameter int unsigned MAX_ELEMENTS = lp_pkg::DEF_MAX_ELEMENTS
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [lp_pkg::DATA_W-1:0]  element_i,
  input  wire logic [lp_pkg::START_W-1:0] start_index_i,
  input  wire logic                       is_last_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [lp_pkg::DATA_W-1:0]       element_out_o,
  output logic [lp_pkg::POS_W-1:0]        position_o,
  output logic [lp_pkg::SPLIT_W-1:0]      split_index_o,
  output logic                            overflow_o,
  output logic                            last_out_o
);

  localparam int unsigned AW = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);

  lp_pkg::lp_state_e state_q, state_d;

  logic [CW-1:0]                  fill_q;
  logic [CW-1:0]                  j_q;
  logic [CW-1:0]                  low_q;
  logic [lp_pkg::START_W-1:0]     base_q;
  logic                           ovf_q;
  logic [lp_pkg::DATA_W-1:0]      pivot_q;
  logic                           out_valid_q;
  logic [lp_pkg::DATA_W-1:0]      element_out_q;
  logic [lp_pkg::POS_W-1:0]       position_q;
  logic [lp_pkg::SPLIT_W-1:0]     split_q;
  logic                           last_q;

  logic                           in_fire;
  logic                           has_room;
  logic                           scan_done;
  logic                           le_pivot;
  logic                           last_w;
  logic [CW+lp_pkg::POS_W-1:0]    pos_ext;

  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr;
  logic [lp_pkg::DATA_W-1:0]      mem_wdata;
  logic                           mem_re;
  logic [lp_pkg::DATA_W-1:0]      rd_a;
  logic [lp_pkg::DATA_W-1:0]      rd_b;

  assign in_ready_o = (state_q == lp_pkg::ST_LOAD);
  assign in_fire    = in_valid_i && in_ready_o;
  assign has_room   = (fill_q < CW'(MAX_ELEMENTS));
  assign scan_done  = (j_q == fill_q);
  assign le_pivot   = ($signed(rd_a) <= $signed(pivot_q));
  assign last_w     = ((j_q + CW'(1)) == fill_q);
  assign pos_ext    = {{lp_pkg::POS_W{1'b0}}, j_q};

  lp_store #(
    .DEPTH (MAX_ELEMENTS),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .re_i      (mem_re),
    .raddr_a_i (j_q[AW-1:0]),
    .raddr_b_i (low_q[AW-1:0]),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lp_pkg::ST_LOAD: begin
        if (in_fire && is_last_i) state_d = lp_pkg::ST_SCAN_RD;
      end
      lp_pkg::ST_SCAN_RD: begin
        state_d = scan_done ? lp_pkg::ST_EMIT_RD : lp_pkg::ST_SCAN_CMP;
      end
      lp_pkg::ST_SCAN_CMP: begin
        state_d = le_pivot ? lp_pkg::ST_SCAN_SWAP : lp_pkg::ST_SCAN_RD;
      end
      lp_pkg::ST_SCAN_SWAP: state_d = lp_pkg::ST_SCAN_RD;
      lp_pkg::ST_EMIT_RD:   state_d = lp_pkg::ST_EMIT_LD;
      lp_pkg::ST_EMIT_LD:   state_d = lp_pkg::ST_EMIT_WAIT;
      lp_pkg::ST_EMIT_WAIT: begin
        if (out_ready_i) state_d = last_q ? lp_pkg::ST_LOAD : lp_pkg::ST_EMIT_RD;
      end
      default: state_d = lp_pkg::ST_LOAD;
    endcase
  end

  // store port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = fill_q[AW-1:0];
    mem_wdata = element_i;
    mem_re    = 1'b0;
    unique case (state_q)
      lp_pkg::ST_LOAD: begin
        mem_we = in_fire && has_room;
      end
      lp_pkg::ST_SCAN_RD: begin
        mem_re = !scan_done;
      end
      lp_pkg::ST_SCAN_CMP: begin
        mem_we    = le_pivot;
        mem_waddr = low_q[AW-1:0];
        mem_wdata = rd_a;
      end
      lp_pkg::ST_SCAN_SWAP: begin
        mem_we    = 1'b1;
        mem_waddr = j_q[AW-1:0];
        mem_wdata = rd_b;
      end
      lp_pkg::ST_EMIT_RD: begin
        mem_re = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lp_pkg::ST_LOAD;
      fill_q      <= '0;
      j_q         <= '0;
      low_q       <= '0;
      base_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        lp_pkg::ST_LOAD: begin
          if (in_fire) begin
            if (fill_q == '0 && !ovf_q) base_q <= start_index_i;
            if (has_room) begin
              fill_q <= fill_q + CW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
            j_q   <= '0;
            low_q <= '0;
          end
        end
        lp_pkg::ST_SCAN_RD: begin
          if (scan_done) j_q <= '0;
        end
        lp_pkg::ST_SCAN_CMP: begin
          if (!le_pivot) j_q <= j_q + CW'(1);
        end
        lp_pkg::ST_SCAN_SWAP: begin
          j_q   <= j_q + CW'(1);
          low_q <= low_q + CW'(1);
        end
        lp_pkg::ST_EMIT_LD: begin
          out_valid_q <= 1'b1;
        end
        lp_pkg::ST_EMIT_WAIT: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            if (last_q) begin
              fill_q <= '0;
              ovf_q  <= 1'b0;
            end else begin
              j_q <= j_q + CW'(1);
            end
          end
        end
        default: begin
          j_q <= j_q;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire && has_room) pivot_q <= element_i;
    if (state_q == lp_pkg::ST_EMIT_LD) begin
      element_out_q <= rd_a;
      position_q    <= pos_ext[lp_pkg::POS_W-1:0];
      split_q       <= {1'b0, base_q} + lp_pkg::SPLIT_W'(low_q) - lp_pkg::SPLIT_W'(1);
      last_q        <= last_w;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign element_out_o = element_out_q;
  assign position_o    = position_q;
  assign split_index_o = split_q;
  assign overflow_o    = ovf_q;
  assign last_out_o    = last_q;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("input ready while a result is pending");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(MAX_ELEMENTS))
    else $error("set count beyond capacity");

  a_low_behind_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lp_pkg::ST_SCAN_RD || state_q == lp_pkg::ST_SCAN_CMP ||
     state_q == lp_pkg::ST_SCAN_SWAP) |-> (low_q <= j_q && j_q <= fill_q))
    else $error("scan pointers out of order");

  a_close_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_last_i) |=> !in_ready_o)
    else $error("input still ready after the closing item");

  a_last_reopens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_out_o) |=> (in_ready_o && fill_q == '0 && !ovf_q))
    else $error("set not cleared after final result");

endmodule

`default_nettype wire
